@@ hw/rtl/cbm_pkg.sv @@
// Package for the cartridge bank mapper.
// Holds the action codes, register indexes, mirroring modes and fixed sizes.
// No dependencies; imported by cartridge_bank_mapper.
package cbm_pkg;

    localparam int unsigned ChrWindows  = 8;
    localparam int unsigned ChrWinBits  = $clog2(ChrWindows);
    localparam int unsigned CfgDataBits = 6;
    localparam int unsigned CfgIdxBits  = 1;
    localparam int unsigned MapBits     = 18;

    typedef enum logic [2:0] {
        ACT_CPU_WRITE = 3'd0,
        ACT_CPU_READ  = 3'd1,
        ACT_PRG_MAP   = 3'd2,
        ACT_CHR_MAP   = 3'd3,
        ACT_NT_MAP    = 3'd4
    } t_action;

    typedef enum logic [CfgIdxBits-1:0] {
        CFG_CHR_SHIFT = 1'd0,
        CFG_PRG_COUNT = 1'd1
    } t_cfg_index;

    typedef enum logic [1:0] {
        MIR_VERTICAL    = 2'd0,
        MIR_HORIZONTAL  = 2'd1,
        MIR_SINGLE_LOW  = 2'd2,
        MIR_SINGLE_HIGH = 2'd3
    } t_mirror;

    localparam logic [3:0] PageWramLo = 4'h6;
    localparam logic [3:0] PageWramHi = 4'h7;
    localparam logic [3:0] PagePrgLow = 4'h8;
    localparam logic [3:0] PageMirror = 4'h9;
    localparam logic [3:0] PagePrgHigh = 4'hA;
    localparam logic [3:0] PageChrFirst = 4'hB;
    localparam logic [3:0] PageChrLast  = 4'hE;

    localparam logic [4:0] PrgBankSecondLast = 5'h1E;
    localparam logic [4:0] PrgBankLast       = 5'h1F;
    localparam logic [5:0] PrgCountReset     = 6'd32;

endpackage

@@ hw/rtl/cartridge_bank_mapper.sv @@
// Cartridge bank mapper: register decode, bank registers and address translation.
// Depends on cbm_pkg.
//
// Channel   Direction  Handshake                      Payload
// in        to block   i_in_valid / o_in_ready        action, bus_address, write_data
// out       from block o_out_valid / i_out_ready      read_data, mapped_address
// cfg       to block   i_cfg_we                       i_cfg_index, i_cfg_data
//
// Decode and bank lookup run in a single pass into the result register,
// and a new word is accepted every cycle while the result
// register is empty or being drained. Bank register updates take effect for the
// next word. Synchronous reset loads the bank registers with their reset values
// and empties the result register. A stalled result holds the input side only
// once the result register is full.
module cartridge_bank_mapper
    import cbm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CfgIdxBits-1:0]  i_cfg_index,
    input  logic [CfgDataBits-1:0] i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [2:0]             i_action,
    input  logic [15:0]            i_bus_address,
    input  logic [7:0]             i_write_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [7:0]             o_read_data,
    output logic [MapBits-1:0]     o_mapped_address
);

    logic                       r_chr_shift;
    logic [5:0]                 r_prg_count;
    logic [4:0]                 r_prg_low;
    logic [4:0]                 r_prg_high;
    logic [7:0]                 r_chr_banks [ChrWindows];
    logic [1:0]                 r_mirror;
    logic                       r_latch;
    logic                       r_out_valid;
    logic [7:0]                 r_read_data;
    logic [MapBits-1:0]         r_mapped;

    logic                       accept;
    logic [3:0]                 page;
    logic [ChrWinBits-1:0]      chr_wr_idx;
    logic [ChrWinBits-1:0]      chr_rd_idx;
    logic [7:0]                 chr_bank;
    logic [4:0]                 prg_mask;
    logic [4:0]                 prg_bank;
    logic                       nt_page;
    logic [7:0]                 n_read_data;
    logic [MapBits-1:0]         n_mapped;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign page       = i_bus_address[15:12];
    assign chr_wr_idx = {2'(page - PageChrFirst), i_bus_address[1]};
    assign chr_rd_idx = i_bus_address[12:10];
    assign chr_bank   = r_chr_banks[chr_rd_idx] >> r_chr_shift;
    assign prg_mask   = 5'(r_prg_count - 6'd1);

    always_comb begin
        case (i_bus_address[14:13])
            2'd0:    prg_bank = r_prg_low;
            2'd1:    prg_bank = r_prg_high;
            2'd2:    prg_bank = PrgBankSecondLast;
            default: prg_bank = PrgBankLast;
        endcase
        case (t_mirror'(r_mirror))
            MIR_VERTICAL:   nt_page = i_bus_address[10];
            MIR_HORIZONTAL: nt_page = i_bus_address[11];
            MIR_SINGLE_LOW: nt_page = 1'b0;
            default:        nt_page = 1'b1;
        endcase
    end

    always_comb begin
        n_read_data = '0;
        n_mapped    = '0;
        case (t_action'(i_action))
            ACT_CPU_READ: begin
                if (i_bus_address[15:13] == 3'd3) begin
                    n_read_data = i_bus_address[15:8] | {7'd0, r_latch};
                end
            end
            ACT_PRG_MAP: begin
                if (i_bus_address[15]) begin
                    n_mapped = {prg_bank & prg_mask, i_bus_address[12:0]};
                end
            end
            ACT_CHR_MAP: n_mapped = {chr_bank, i_bus_address[9:0]};
            ACT_NT_MAP:  n_mapped = {7'd0, nt_page, i_bus_address[9:0]};
            default: begin
                n_read_data = '0;
                n_mapped    = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chr_shift <= 1'b0;
            r_prg_count <= PrgCountReset;
            r_prg_low   <= '0;
            r_prg_high  <= '0;
            r_mirror    <= MIR_VERTICAL;
            r_latch     <= 1'b0;
            for (int i = 0; i < ChrWindows; i++) begin
                r_chr_banks[i] <= 8'(i);
            end
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_CHR_SHIFT: r_chr_shift <= i_cfg_data[0];
                    CFG_PRG_COUNT: r_prg_count <= i_cfg_data;
                    default:       r_prg_count <= r_prg_count;
                endcase
            end
            if (accept && t_action'(i_action) == ACT_CPU_WRITE) begin
                if (page == PageWramLo || page == PageWramHi) begin
                    r_latch <= i_write_data[0];
                end else if (page == PagePrgLow) begin
                    r_prg_low <= i_write_data[4:0];
                end else if (page == PageMirror) begin
                    r_mirror <= i_write_data[1:0];
                end else if (page == PagePrgHigh) begin
                    r_prg_high <= i_write_data[4:0];
                end else if (page >= PageChrFirst && page <= PageChrLast) begin
                    if (i_bus_address[0]) begin
                        r_chr_banks[chr_wr_idx][7:4] <= i_write_data[3:0];
                    end else begin
                        r_chr_banks[chr_wr_idx][3:0] <= i_write_data[3:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_read_data <= n_read_data;
            r_mapped    <= n_mapped;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_read_data      = r_read_data;
    assign o_mapped_address = r_mapped;

`ifndef SYNTH
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("Input stalled while the result register is empty.");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> o_out_valid)
        else $error("Accepted word produced no result.");

    a_one_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_read_data == 8'd0 || o_mapped_address == '0))
        else $error("Read data and mapped address both nonzero.");
`endif

endmodule
